// ----- sv/lcne_pkg.sv -----
// lcne_pkg: shared types, codes, digit-step program and numeral tables
// for the list counter numeral encoder.
// No dependencies.
package lcne_pkg;

  localparam int VALUE_BITS_DEF = 12;
  localparam int MAX_CHARS_DEF  = 64;

  localparam int VAL_W   = 12;  // counter_value width
  localparam int CHAR_W  = 12;  // char_code width
  localparam int STYLE_W = 4;
  localparam int IDX_W   = 2;   // config register index
  localparam int CFG_W   = 4;   // widest config register
  localparam int DIG_W   = 8;
  localparam int NSLOT   = 4;

  // numeral_style codes
  localparam logic [STYLE_W-1:0] STYLE_DECIMAL      = 4'd0;
  localparam logic [STYLE_W-1:0] STYLE_ROMAN        = 4'd1;
  localparam logic [STYLE_W-1:0] STYLE_ALPHA        = 4'd2;
  localparam logic [STYLE_W-1:0] STYLE_SCRIPT_FIRST = 4'd3;
  localparam logic [STYLE_W-1:0] STYLE_SCRIPT_LAST  = 4'd12;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_STYLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_UPPER = 2'd1;
  localparam logic [IDX_W-1:0] REG_SYNC  = 2'd2;

  // emission modes
  localparam logic [1:0] MODE_DEC   = 2'd0;
  localparam logic [1:0] MODE_ROMAN = 2'd1;
  localparam logic [1:0] MODE_ALPHA = 2'd2;
  localparam logic [1:0] MODE_SYNC  = 2'd3;

  // digit-unit programs
  localparam logic [1:0] PROG_DEC   = 2'd0;
  localparam logic [1:0] PROG_ALPHA = 2'd1;
  localparam logic [1:0] PROG_SYNC  = 2'd2;

  // roman symbol kinds within one decimal place
  localparam logic [1:0] SYM_ONE  = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_TEN  = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 12'h030;
  localparam logic [7:0] LETTER_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] LETTER_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CASE_SHIFT   = 8'd32;
  localparam logic [VAL_W-1:0] ROMAN_MAX = 12'd3999;

  typedef logic [NSLOT-1:0][DIG_W-1:0] digits_t;

  typedef struct packed {
    logic [11:0]      weight;
    logic [1:0]       slot;
    logic [DIG_W-1:0] bitval;
    logic             last;
  } step_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              err;
    logic              upper;
    logic [CHAR_W-1:0] zero;
    logic [1:0]        nletters;
  } job_t;

  function automatic step_t mk_step(input int w, input int sl, input int b, input logic l);
    step_t s;
    s.weight = 12'(w);
    s.slot   = 2'(sl);
    s.bitval = 8'(b);
    s.last   = l;
    return s;
  endfunction

  // One compare-subtract per step: weight = place value times a binary digit weight.
  function automatic step_t step_f(input logic [1:0] prog, input logic [3:0] idx);
    step_t s;
    s = mk_step(0, 0, 0, 1'b1);
    case (prog)
      PROG_DEC: begin
        case (idx)
          4'd0:  s = mk_step(4000, 3, 4, 1'b0);
          4'd1:  s = mk_step(2000, 3, 2, 1'b0);
          4'd2:  s = mk_step(1000, 3, 1, 1'b0);
          4'd3:  s = mk_step(800,  2, 8, 1'b0);
          4'd4:  s = mk_step(400,  2, 4, 1'b0);
          4'd5:  s = mk_step(200,  2, 2, 1'b0);
          4'd6:  s = mk_step(100,  2, 1, 1'b0);
          4'd7:  s = mk_step(80,   1, 8, 1'b0);
          4'd8:  s = mk_step(40,   1, 4, 1'b0);
          4'd9:  s = mk_step(20,   1, 2, 1'b0);
          4'd10: s = mk_step(10,   1, 1, 1'b1);
          default: s = mk_step(0, 0, 0, 1'b1);
        endcase
      end
      PROG_ALPHA: begin
        case (idx)
          4'd0: s = mk_step(2704, 2, 4,  1'b0);
          4'd1: s = mk_step(1352, 2, 2,  1'b0);
          4'd2: s = mk_step(676,  2, 1,  1'b0);
          4'd3: s = mk_step(416,  1, 16, 1'b0);
          4'd4: s = mk_step(208,  1, 8,  1'b0);
          4'd5: s = mk_step(104,  1, 4,  1'b0);
          4'd6: s = mk_step(52,   1, 2,  1'b0);
          4'd7: s = mk_step(26,   1, 1,  1'b1);
          default: s = mk_step(0, 0, 0, 1'b1);
        endcase
      end
      PROG_SYNC: begin
        case (idx)
          4'd0: s = mk_step(832, 1, 32, 1'b0);
          4'd1: s = mk_step(416, 1, 16, 1'b0);
          4'd2: s = mk_step(208, 1, 8,  1'b0);
          4'd3: s = mk_step(104, 1, 4,  1'b0);
          4'd4: s = mk_step(52,  1, 2,  1'b0);
          4'd5: s = mk_step(26,  1, 1,  1'b1);
          default: s = mk_step(0, 0, 0, 1'b1);
        endcase
      end
      default: s = mk_step(0, 0, 0, 1'b1);
    endcase
    return s;
  endfunction

  // Zero digit of the Indic, Tibetan and Thai scripts
  function automatic logic [CHAR_W-1:0] script_zero(input logic [STYLE_W-1:0] style);
    logic [CHAR_W-1:0] z;
    case (style)
      4'd3:  z = 12'h9e6;  // bengali
      4'd4:  z = 12'hae6;  // gujarati
      4'd5:  z = 12'ha66;  // gurmukhi
      4'd6:  z = 12'hce6;  // kannada
      4'd7:  z = 12'hd66;  // malayalam
      4'd8:  z = 12'hb66;  // oriya
      4'd9:  z = 12'hbe6;  // tamil
      4'd10: z = 12'hc66;  // telugu
      4'd11: z = 12'hf20;  // tibetan
      4'd12: z = 12'he50;  // thai
      default: z = ASCII_ZERO;
    endcase
    return z;
  endfunction

  // Roman pattern length for one decimal digit
  function automatic logic [2:0] rom_len(input logic [3:0] d);
    logic [2:0] l;
    case (d)
      4'd1, 4'd5:       l = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: l = 3'd2;
      4'd3, 4'd7:       l = 3'd3;
      4'd8:             l = 3'd4;
      default:          l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [1:0] rom_sym(input logic [3:0] d, input logic [2:0] pos);
    logic [1:0] s;
    if (d == 4'd4) begin
      s = (pos == 3'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d == 4'd9) begin
      s = (pos == 3'd0) ? SYM_ONE : SYM_TEN;
    end else if (d >= 4'd5) begin
      s = (pos == 3'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  // Lower-case roman letter for place (0 units .. 3 thousands) and symbol kind
  function automatic logic [7:0] rom_letter(input logic [1:0] place, input logic [1:0] sym);
    logic [7:0] c;
    case (place)
      2'd0:    c = (sym == SYM_ONE) ? 8'h69 : (sym == SYM_FIVE) ? 8'h76 : 8'h78; // i v x
      2'd1:    c = (sym == SYM_ONE) ? 8'h78 : (sym == SYM_FIVE) ? 8'h6c : 8'h63; // x l c
      2'd2:    c = (sym == SYM_ONE) ? 8'h63 : (sym == SYM_FIVE) ? 8'h64 : 8'h6d; // c d m
      default: c = 8'h6d;                                                        // m
    endcase
    return c;
  endfunction

endpackage

// ----- sv/list_counter_numeral_encoder_unit.sv -----
// list_counter_numeral_encoder_unit: top level of the numeral encoder.
// Holds the config registers, style decode and sequencer; uses
// lcne_digit_unit, lcne_emitter and lcne_pkg.
//
//   channel | signals                                  | role
//   --------+------------------------------------------+-------------------------
//   in      | in_valid, in_ready, counter_value        | one counter value
//   out     | out_valid, out_ready, char_code,         | one character per
//           | last_char, range_error                   | transaction, MSB first
//   cfg     | cfg_we, cfg_index, cfg_data              | register write, no wait
//
// Sequence: an item is accepted, then 11 (decimal, script, roman),
//   8 (alphabetic) or 6 (letter-synchronised) compare-subtract steps run in the
//   digit unit, the digits are handed over, and emission walks one decimal
//   place or one character at a time (leading roman places holding zero are
//   each skipped in a step of their own); a closing step in the sequencer
//   comes before in_ready returns.
// Reset clears the config registers to decimal, lower case, bijective letters.
// A stalled out channel holds emission; the next item is taken while the last
//   character of the previous one still waits in the output register.
module list_counter_numeral_encoder_unit #(
  parameter int VALUE_BITS = lcne_pkg::VALUE_BITS_DEF,
  parameter int MAX_CHARS  = lcne_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [lcne_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lcne_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcne_pkg::VAL_W-1:0]    counter_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcne_pkg::CHAR_W-1:0]   char_code,
  output logic                          last_char,
  output logic                          range_error
);

  localparam int VW = lcne_pkg::VAL_W;
  // only the low VALUE_BITS of the counter are used
  localparam int VMASK_INT = (VALUE_BITS >= VW) ? ((1 << VW) - 1) : ((1 << VALUE_BITS) - 1);
  localparam logic [VW-1:0] VALUE_MASK = VW'(VMASK_INT);
  // letter-synchronised limit: 26 letters times the longest numeral
  localparam logic [VW-1:0] SYNC_LIMIT = VW'(26 * MAX_CHARS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                    state;
  logic [lcne_pkg::STYLE_W-1:0]  numeral_style;
  logic                          upper_case;
  logic                          letter_sync;

  logic [VW-1:0]                 n;
  logic [VW-1:0]                 uval;
  logic [1:0]                    prog;
  lcne_pkg::job_t                job;
  lcne_pkg::job_t                job_r;
  logic                          accept;
  logic                          unit_done;
  lcne_pkg::digits_t             digits;
  logic                          emit_start;
  logic                          emit_busy;

  assign in_ready   = state == ST_IDLE;
  assign accept     = in_valid && in_ready;
  assign n          = counter_value & VALUE_MASK;
  assign emit_start = (state == ST_CONV) && unit_done;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      numeral_style <= lcne_pkg::STYLE_DECIMAL;
      upper_case    <= 1'b0;
      letter_sync   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcne_pkg::REG_STYLE: numeral_style <= cfg_data;
        lcne_pkg::REG_UPPER: upper_case    <= cfg_data[0];
        lcne_pkg::REG_SYNC:  letter_sync   <= cfg_data[0];
        default: ;  // no register here
      endcase
    end
  end

  // Style decode. An unformable value keeps the decimal defaults and flags err,
  // which gives the ASCII fallback.
  always_comb begin
    job.mode     = lcne_pkg::MODE_DEC;
    job.err      = 1'b0;
    job.upper    = upper_case;
    job.zero     = lcne_pkg::ASCII_ZERO;
    job.nletters = 2'd1;
    uval         = n;
    prog         = lcne_pkg::PROG_DEC;
    case (numeral_style) inside
      lcne_pkg::STYLE_ROMAN: begin
        if (n == '0 || n > lcne_pkg::ROMAN_MAX) begin
          job.err = 1'b1;
        end else begin
          job.mode = lcne_pkg::MODE_ROMAN;
        end
      end
      lcne_pkg::STYLE_ALPHA: begin
        if (n == '0) begin
          job.err = 1'b1;
        end else if (letter_sync) begin
          if (n > SYNC_LIMIT) begin
            job.err = 1'b1;
          end else begin
            job.mode = lcne_pkg::MODE_SYNC;
            prog     = lcne_pkg::PROG_SYNC;
            uval     = n - VW'(1);
          end
        end else begin
          // bijective: strip the count of shorter numerals, then plain base 26
          job.mode = lcne_pkg::MODE_ALPHA;
          prog     = lcne_pkg::PROG_ALPHA;
          if (n <= VW'(26)) begin
            job.nletters = 2'd1;
            uval         = n - VW'(1);
          end else if (n <= VW'(702)) begin
            job.nletters = 2'd2;
            uval         = n - VW'(27);
          end else begin
            job.nletters = 2'd3;
            uval         = n - VW'(703);
          end
        end
      end
      [lcne_pkg::STYLE_SCRIPT_FIRST:lcne_pkg::STYLE_SCRIPT_LAST]: begin
        if (n == '0) begin
          job.err = 1'b1;
        end else begin
          job.zero = lcne_pkg::script_zero(numeral_style);
        end
      end
      default: ;  // decimal and the unused codes
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= ST_CONV;
        ST_CONV: if (unit_done) state <= ST_EMIT;
        ST_EMIT: if (!emit_busy) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job;
    end
  end

  lcne_digit_unit u_digits (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .prog   (prog),
    .value  (uval),
    .done   (unit_done),
    .digits (digits)
  );

  lcne_emitter #(
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .start       (emit_start),
    .job         (job_r),
    .digits      (digits),
    .busy        (emit_busy),
    .char_code   (char_code),
    .last_char   (last_char),
    .range_error (range_error),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

// ----- sv/lcne_digit_unit.sv -----
// lcne_digit_unit: iterative digit extraction by one shared compare-subtract.
// Runs a step program from lcne_pkg, one step per cycle.
// Depends on lcne_pkg.
module lcne_digit_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  prog,
  input  logic [lcne_pkg::VAL_W-1:0]  value,
  output logic                        done,
  output lcne_pkg::digits_t           digits
);

  logic [lcne_pkg::VAL_W-1:0] rem;
  logic [lcne_pkg::VAL_W-1:0] rem_next;
  logic [3:0]                 idx;
  logic [1:0]                 prog_r;
  logic                       running;
  lcne_pkg::step_t            st;
  lcne_pkg::digits_t          digits_next;
  logic                       ge;
  logic [lcne_pkg::VAL_W-1:0] diff;

  // the shared unit
  assign st   = lcne_pkg::step_f(prog_r, idx);
  assign ge   = rem >= st.weight;
  assign diff = rem - st.weight;

  always_comb begin
    rem_next    = ge ? diff : rem;
    digits_next = digits;
    if (ge) begin
      digits_next[st.slot] = digits[st.slot] | st.bitval;
    end
    if (st.last) begin
      digits_next[0] = lcne_pkg::DIG_W'(rem_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && st.last) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= value;
      idx    <= '0;
      prog_r <= prog;
      digits <= '0;
    end else if (running) begin
      rem    <= rem_next;
      idx    <= idx + 4'd1;
      digits <= digits_next;
    end
  end

endmodule

// ----- sv/lcne_emitter.sv -----
// lcne_emitter: walks the extracted digits and presents one character per
// transaction through an output register. Depends on lcne_pkg.
module lcne_emitter #(
  parameter int MAX_CHARS = lcne_pkg::MAX_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lcne_pkg::job_t               job,
  input  lcne_pkg::digits_t            digits,
  output logic                         busy,
  output logic [lcne_pkg::CHAR_W-1:0]  char_code,
  output logic                         last_char,
  output logic                         range_error,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int RW = $clog2(MAX_CHARS);

  lcne_pkg::job_t             job_r;
  logic                       active;
  logic [1:0]                 place;
  logic [1:0]                 place_next;
  logic [2:0]                 pos;
  logic [2:0]                 pos_next;
  logic [RW-1:0]              rep;
  logic [RW-1:0]              rep_next;
  logic                       started;
  logic                       started_next;
  logic                       go;
  logic                       emit;
  logic                       fin;
  logic                       is_last;
  logic [lcne_pkg::CHAR_W-1:0] ch;
  logic [lcne_pkg::DIG_W-1:0] cur;
  logic [2:0]                 rlen;
  logic [7:0]                 base;
  logic [7:0]                 rletter;
  logic [3:0]                 lz;     // all places below are zero

  assign cur     = digits[place];
  assign rlen    = lcne_pkg::rom_len(cur[3:0]);
  assign base    = job_r.upper ? lcne_pkg::LETTER_UPPER : lcne_pkg::LETTER_LOWER;
  assign rletter = lcne_pkg::rom_letter(place, lcne_pkg::rom_sym(cur[3:0], pos))
                   - (job_r.upper ? lcne_pkg::CASE_SHIFT : 8'd0);

  assign lz[0] = 1'b1;
  assign lz[1] = digits[0] == '0;
  assign lz[2] = lz[1] && (digits[1] == '0);
  assign lz[3] = lz[2] && (digits[2] == '0);

  assign go = active && (!out_valid || out_ready);

  always_comb begin
    emit         = 1'b0;
    fin          = 1'b0;
    is_last      = 1'b0;
    ch           = '0;
    place_next   = place;
    pos_next     = pos;
    rep_next     = rep;
    started_next = started;
    unique case (job_r.mode)
      lcne_pkg::MODE_DEC: begin
        // leading zeros skipped, units always shown
        emit    = started || (cur[3:0] != 4'd0) || (place == 2'd0);
        ch      = job_r.zero + lcne_pkg::CHAR_W'(cur[3:0]);
        is_last = place == 2'd0;
        if (emit) begin
          started_next = 1'b1;
        end
        if (place == 2'd0) begin
          fin = 1'b1;
        end else begin
          place_next = place - 2'd1;
        end
      end
      lcne_pkg::MODE_ALPHA: begin
        emit    = 1'b1;
        ch      = lcne_pkg::CHAR_W'(base) + lcne_pkg::CHAR_W'(cur[4:0]);
        is_last = place == 2'd0;
        if (place == 2'd0) begin
          fin = 1'b1;
        end else begin
          place_next = place - 2'd1;
        end
      end
      lcne_pkg::MODE_SYNC: begin
        // quotient in slot 1 is repeat count minus one, letter in slot 0
        emit     = 1'b1;
        ch       = lcne_pkg::CHAR_W'(base) + lcne_pkg::CHAR_W'(digits[0][4:0]);
        is_last  = rep == digits[1][RW-1:0];
        fin      = is_last;
        rep_next = rep + RW'(1);
      end
      lcne_pkg::MODE_ROMAN: begin
        if (rlen == 3'd0) begin
          place_next = place - 2'd1;
        end else begin
          emit    = 1'b1;
          ch      = lcne_pkg::CHAR_W'(rletter);
          is_last = (pos == rlen - 3'd1) && lz[place];
          if (pos == rlen - 3'd1) begin
            pos_next = 3'd0;
            if (lz[place]) begin
              fin = 1'b1;
            end else begin
              place_next = place - 2'd1;
            end
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
      end else if (go && fin) begin
        active <= 1'b0;
      end
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_r   <= job;
      place   <= (job.mode == lcne_pkg::MODE_ALPHA) ? job.nletters - 2'd1 : 2'd3;
      pos     <= 3'd0;
      rep     <= '0;
      started <= 1'b0;
    end else if (go) begin
      place   <= place_next;
      pos     <= pos_next;
      rep     <= rep_next;
      started <= started_next;
    end
    if (go && emit) begin
      char_code   <= ch;
      last_char   <= is_last;
      range_error <= job_r.err;
    end
  end

  assign busy = active;

endmodule

// ----- sv/lcne_checker.sv -----
// lcne_checker: port-level assertions for the numeral encoder, bound to
// list_counter_numeral_encoder_unit. Depends on lcne_pkg.
module lcne_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lcne_pkg::CHAR_W-1:0] char_code,
  input logic                        last_char,
  input logic                        range_error
);

  // after reset the block is ready and shows no transaction
  a_reset: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // one item at a time: taking an item drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after input transaction");

  // the fallback is always ASCII decimal digits
  a_fallback: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (char_code >= lcne_pkg::ASCII_ZERO &&
                                    char_code <= lcne_pkg::ASCII_ZERO + 12'd9))
    else $error("fallback character is not an ASCII digit");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(char_code) &&
                                  $stable(last_char) && $stable(range_error))
    else $error("stalled output transaction changed");

endmodule

bind list_counter_numeral_encoder_unit lcne_checker u_lcne_checker (.*);
